>>> rtl/core/assert_macros.svh
// Assertion macros for the RTL; used by the packer top level.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> rtl/core/rgbp_pkg.sv
// Package for the RGB float to R11G11B10 packer.
// Constants and the per-channel code type; no dependencies.
package rgbp_pkg;
  localparam int unsigned InWidth = 32;
  localparam int unsigned OutWidth = 32;
  localparam int unsigned RgMantBits = 6;
  localparam int unsigned BMantBits = 5;
  localparam int unsigned ExpBits = 5;
  localparam logic [7:0] SrcBias = 8'd127;
  localparam logic [4:0] TopExp = 5'd30;
  localparam logic [4:0] ExpLimit = 5'd31;
  typedef logic [ExpBits+RgMantBits-1:0] rg_code_t;
  typedef logic [ExpBits+BMantBits-1:0] b_code_t;
endpackage

>>> rtl/core/rgbp_lane.sv
// One channel encoder: single precision bits to unsigned small float.
// Depends on rgbp_pkg.
module rgbp_lane import rgbp_pkg::*; #(
  parameter int unsigned MantBits = RgMantBits
) (
  input  logic [InWidth-1:0]          bits_i,
  output logic [ExpBits+MantBits-1:0] code_o
);
  localparam int unsigned CodeW = ExpBits + MantBits;
  localparam logic [CodeW-1:0] MaxCode = {TopExp, {MantBits{1'b1}}};

  logic [7:0]  efield;
  logic [23:0] sig;
  logic [4:0]  sh;
  logic [23:0] qv;
  logic [23:0] rem;
  logic [23:0] half;
  logic        up;
  logic [MantBits+1:0] q;
  logic [5:0]  texp;

  always_comb begin
    efield = bits_i[30:23];
    sig    = {1'b1, bits_i[22:0]};
    code_o = '0;
    // normal: shift 23-M; subnormal: 9-M-e = 136-M-efield
    if (efield < 8'd113) begin
      sh = 5'(8'd136 - 8'(MantBits) - efield);
    end else begin
      sh = 5'(23 - MantBits);
    end
    qv   = sig >> sh;
    rem  = sig & ((24'd1 << sh) - 24'd1);
    half = 24'd1 << (sh - 5'd1);
    up   = (rem > half) || ((rem == half) && qv[0]);
    q    = (MantBits + 2)'(qv) + (MantBits + 2)'(up);
    texp = 6'(efield) - 6'(SrcBias) + 6'd15;
    if (bits_i[31] || efield == 8'd0) begin
      code_o = '0;
    end else if (efield > 8'd142) begin
      code_o = MaxCode;
    end else if (efield < 8'd113) begin
      if (efield < 8'(112 - MantBits)) code_o = '0;
      else code_o = CodeW'(q);
    end else if (q[MantBits+1]) begin
      if (texp + 6'd1 >= 6'(ExpLimit)) code_o = MaxCode;
      else code_o = {5'(texp + 6'd1), MantBits'(0)};
    end else begin
      if (texp >= 6'(ExpLimit)) code_o = MaxCode;
      else code_o = {texp[4:0], q[MantBits-1:0]};
    end
  end
endmodule

>>> rtl/core/rgbp_merge.sv
// Merge stage: packs the three lane codes into one registered word with a skid slot.
// Depends on rgbp_pkg.
module rgbp_merge import rgbp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  rg_code_t            red_i,
  input  rg_code_t            green_i,
  input  b_code_t             blue_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [OutWidth-1:0] data_o
);
  logic                valid_q, valid_d, skid_q, skid_d;
  logic [OutWidth-1:0] data_q, skid_data_q, word;

  assign word    = {blue_i, green_i, red_i};
  assign ready_o = !skid_q;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    valid_d = valid_q;
    skid_d  = skid_q;
    if (!valid_q || ready_i) begin
      valid_d = skid_q || valid_i;
      skid_d  = 1'b0;
    end else if (valid_i && !skid_q) begin
      skid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      skid_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      skid_q  <= skid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!valid_q || ready_i) begin
      data_q <= skid_q ? skid_data_q : word;
    end
    if (valid_i && !skid_q && valid_q && !ready_i) begin
      skid_data_q <= word;
    end
  end
endmodule

>>> rtl/core/rgb_float_to_r11g11b10_pack.sv
// Top level of the RGB float to R11G11B10 packer.
// Depends on rgbp_pkg, rgbp_lane, rgbp_merge and assert_macros.svh.
// One transaction per clock while the skid slot is empty: three encoder lanes
// convert the channels in parallel into a registered packed word. A two-entry
// output stage lets input keep flowing into the skid slot during output stall.
`include "assert_macros.svh"
module rgb_float_to_r11g11b10_pack import rgbp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [3*InWidth-1:0] s_axis_tdata,  // red_bits, green_bits, blue_bits
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutWidth-1:0] m_axis_tdata   // packed_word
);
  rg_code_t red_code, green_code;
  b_code_t  blue_code;

  rgbp_lane #(.MantBits(RgMantBits)) u_red (
    .bits_i(s_axis_tdata[InWidth-1:0]), .code_o(red_code));
  rgbp_lane #(.MantBits(RgMantBits)) u_green (
    .bits_i(s_axis_tdata[2*InWidth-1:InWidth]), .code_o(green_code));
  rgbp_lane #(.MantBits(BMantBits)) u_blue (
    .bits_i(s_axis_tdata[3*InWidth-1:2*InWidth]), .code_o(blue_code));

  rgbp_merge u_merge (
    .clk_i, .rst_ni,
    .valid_i(s_axis_tvalid), .ready_o(s_axis_tready),
    .red_i(red_code), .green_i(green_code), .blue_i(blue_code),
    .valid_o(m_axis_tvalid), .ready_i(m_axis_tready), .data_o(m_axis_tdata));

  `ASSERT_CLK(a_out_after_in, (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid, "no output")
  `ASSERT_RST(a_reset_idle, !rst_ni |-> !m_axis_tvalid, "valid during reset")
endmodule

>>> sim/tb_top.sv
// Testbench for rgb_float_to_r11g11b10_pack: directed table plus random pixels.
// Predicts each packed word from the three float channels; depends on rgbp_pkg and the RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rgbp_pkg::*;

  typedef struct packed {
    logic [31:0] blue;
    logic [31:0] green;
    logic [31:0] red;
  } pixel_t;

  typedef struct {
    pixel_t      px;
    logic        known;
    logic [31:0] word;
  } row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [3*InWidth-1:0] s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutWidth-1:0]  m_axis_tdata;

  logic [31:0] packed_q[$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  row_t        dir_rows[$];

  rgb_float_to_r11g11b10_pack dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [31:0] round_shift(logic [23:0] sig, int sh);
    logic [31:0] half, rem, q;
    half = 32'd1 << (sh - 1);
    rem  = sig & ((32'd1 << sh) - 1);
    q    = sig >> sh;
    if (rem > half || (rem == half && q[0])) q++;
    return q;
  endfunction

  function automatic logic [31:0] to_ufloat(logic [31:0] f, int mb);
    logic [31:0] maxc, q, tex;
    logic [23:0] sig;
    int e;
    maxc = (32'(TopExp) << mb) | ((32'd1 << mb) - 1);
    if (f[31] || f[30:23] == 8'd0) return 0;
    e = int'(f[30:23]) - int'(SrcBias);
    if (e > 15) return maxc;
    sig = {1'b1, f[22:0]};
    if (e < -14) begin
      if (e < -15 - mb) return 0;
      return round_shift(sig, 9 - mb - e);
    end
    q = round_shift(sig, 23 - mb);
    tex = 32'(e + 15);
    if (q == (32'd1 << (mb + 1))) begin
      tex++;
      q >>= 1;
    end
    if (tex >= 32'(ExpLimit)) return maxc;
    return (tex << mb) | (q & ((32'd1 << mb) - 1));
  endfunction

  function automatic logic [31:0] pack_pixel(pixel_t p);
    logic [31:0] rc, gc, bc;
    rc = to_ufloat(p.red, RgMantBits);
    gc = to_ufloat(p.green, RgMantBits);
    bc = to_ufloat(p.blue, BMantBits);
    return {bc[9:0], gc[10:0], rc[10:0]};
  endfunction

  function automatic logic [31:0] rand_float();
    logic [31:0] f;
    f = $urandom;
    case ($urandom_range(0, 5))
      0, 1: f[30:23] = 8'($urandom_range(127 - 22, 127 + 16));
      2: f[30:23] = 8'($urandom_range(127 - 15, 127 - 13));
      3: f[22:0] = {$urandom_range(0, 1) ? 23'h7fffff : 23'h0} ^ 23'($urandom_range(0, 7));
      default: ;
    endcase
    if ($urandom_range(0, 3) != 0) f[31] = 1'b0;
    return f;
  endfunction

  task automatic send_pixel(pixel_t p);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= p;
    packed_q.insert(packed_q.size(), pack_pixel(p));
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (packed_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (packed_q.size() == 0) begin
          $display("%0t unexpected word: expected none, actual %h", $time, m_axis_tdata);
          errors++;
        end else begin
          if (packed_q[0] !== m_axis_tdata) begin
            $display("%0t packed_word: expected %h, actual %h", $time, packed_q[0],
                     m_axis_tdata);
            errors++;
          end
          void'(packed_q.pop_front());
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    row_t r;
    pixel_t p;
    #1 rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: zero, -0, inf, nan, -1, denorm, max, subnormal edges, rounding ties
    dir_rows.insert(dir_rows.size(), '{'{32'h0, 32'h0, 32'h0}, 1'b1, 32'h0});
    dir_rows.insert(dir_rows.size(),
                    '{'{32'h80000000, 32'hbf800000, 32'hff800000}, 1'b1, 32'h0});
    dir_rows.insert(dir_rows.size(), '{'{32'h7f800000, 32'h7fc00000, 32'h7f800000}, 1'b1,
                                       {10'h3df, 11'h7bf, 11'h7bf}});
    dir_rows.insert(dir_rows.size(),
                    '{'{32'h00000001, 32'h007fffff, 32'hffffffff}, 1'b1, 32'h0});
    dir_rows.insert(dir_rows.size(), '{'{32'h477e0000, 32'h477f0000, 32'h7f7fffff}, 1'b1,
                                       {10'h3df, 11'h7bf, 11'h7bf}});
    dir_rows.insert(dir_rows.size(),
                    '{'{32'h3f800000, 32'h3f800000, 32'h3f800000}, 1'b0, 32'h0});
    dir_rows.insert(dir_rows.size(),
                    '{'{32'h38800000, 32'h38000000, 32'h387fffff}, 1'b0, 32'h0});
    dir_rows.insert(dir_rows.size(),
                    '{'{32'h35000000, 32'h34800000, 32'h35800000}, 1'b0, 32'h0});
    dir_rows.insert(dir_rows.size(),
                    '{'{32'h3f808000, 32'h3f818000, 32'h3f810000}, 1'b0, 32'h0});
    dir_rows.insert(dir_rows.size(),
                    '{'{32'h3fff0000, 32'h3fffffff, 32'h3ff80000}, 1'b0, 32'h0});
    dir_rows.insert(dir_rows.size(),
                    '{'{32'h477c0000, 32'h477c1000, 32'h477a0000}, 1'b0, 32'h0});
    dir_rows.insert(dir_rows.size(),
                    '{'{32'h387f0000, 32'h387e0000, 32'h387c0000}, 1'b0, 32'h0});
    dir_rows.insert(dir_rows.size(),
                    '{'{32'h7fffffff, 32'h55555555, 32'h2aaaaaaa}, 1'b0, 32'h0});
    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.known && r.word !== pack_pixel(r.px)) begin
        $display("%0t table row %0d: expected %h, actual %h", $time, i, r.word,
                 pack_pixel(r.px));
        errors++;
      end
      send_pixel(r.px);
    end
    wait_drain();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? 57 : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? 57 : 0;
      if (ph == 3) begin
        send_idle_pct  = 19;
        recv_stall_pct = 19;
      end
      for (int n = 0; n < 400; n++) begin
        p.red   = rand_float();
        p.green = rand_float();
        p.blue  = rand_float();
        send_pixel(p);
        if (n == 200) wait_drain();
      end
    end
    wait_drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end
endmodule

>>> rgb_float_to_r11g11b10_pack.f
+incdir+rtl/core
rtl/core/rgbp_pkg.sv
rtl/core/rgbp_lane.sv
rtl/core/rgbp_merge.sv
rtl/core/rgb_float_to_r11g11b10_pack.sv
sim/tb_top.sv
